@@ rtl/rhtm_pkg.sv @@
// shared types, constants and the gamma table generator for the rgbe tone map block
// no dependencies; used by every module under rtl
package rhtm_pkg;

    // widths and channel count
    localparam int unsigned MANT_W = 8;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned Y_BITS = 16;
    localparam int unsigned CHANNELS = 3;
    localparam int unsigned GAMMA_BITS_DEF = 12;

    // 65504 * 255, the largest linear numerator
    localparam logic [FRAC_W-1:0] SAT_NUM = 24'd16703520;
    localparam logic [FRAC_W-1:0] SCALE_255 = 24'd255;

    // numerator or running remainder with its divisor
    typedef struct packed {
        logic [FRAC_W-1:0] num;
        logic [FRAC_W-1:0] den;
    } frac_t;

    // largest v in 0..255 with v^11 * 2^(5*gbits) <= 255^11 * idx^5
    function automatic logic [7:0] gamma_entry(input int unsigned idx,
                                               input int unsigned gbits);
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int k;
        rhs = 192'd1;
        for (k = 0; k < 11; k++) rhs = rhs * 192'd255;
        for (k = 0; k < 5; k++) rhs = rhs * 192'(idx);
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 192'd1;
            for (k = 0; k < 11; k++) lhs = lhs * 192'(mid);
            lhs = lhs << (5 * gbits);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return 8'(lo);
    endfunction

endpackage

@@ rtl/rhtm_prep.sv @@
// front end of one channel: turns mantissa and shared exponent into numerator and divisor
// depends on rhtm_pkg
module rhtm_prep import rhtm_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [MANT_W-1:0]        mant,
    input  logic signed [MANT_W-1:0] expo,
    output frac_t                    frac_reg
);

    logic [30:0]        shifted;
    logic [MANT_W-1:0]  neg_expo;
    logic [4:0]         k;
    frac_t              frac_next;

    // y = n / (255 + n) for e >= 0, c / (255 * 2^k + c) for e = -k
    always_comb begin
        shifted  = 31'(mant) << expo[4:0];
        neg_expo = MANT_W'(-expo);
        k        = neg_expo[4:0];
        if (mant == '0 || expo < -8'sd16) begin
            frac_next.num = '0;
            frac_next.den = SCALE_255;
        end else if (expo[MANT_W-1]) begin
            frac_next.num = FRAC_W'(mant);
            frac_next.den = (SCALE_255 << k) + FRAC_W'(mant);
        end else if (expo >= 8'sd24 || shifted > 31'(SAT_NUM)) begin
            frac_next.num = SAT_NUM;
            frac_next.den = SAT_NUM + SCALE_255;
        end else begin
            frac_next.num = shifted[FRAC_W-1:0];
            frac_next.den = shifted[FRAC_W-1:0] + SCALE_255;
        end
    end

    // input stage register
    always_ff @(posedge aclk) begin
        if (en) frac_reg <= frac_next;
    end

endmodule

@@ rtl/rhtm_div.sv @@
// pipelined restoring divider, one quotient bit per stage, floor(num * 2^16 / den)
// depends on rhtm_pkg; expects num < den
module rhtm_div import rhtm_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  frac_t             frac_in,
    output logic [Y_BITS-1:0] y_out
);

    frac_t             st_reg [Y_BITS];
    logic [Y_BITS-1:0] q_reg  [Y_BITS];

    for (genvar j = 0; j < Y_BITS; j++) begin : g_stage
        frac_t             src;
        logic [Y_BITS-1:0] src_q;
        logic [FRAC_W:0]   twice;
        logic [FRAC_W:0]   diff;
        logic              fits;
        frac_t             st_next;
        logic [Y_BITS-1:0] q_next;

        // first stage takes the prepared fraction, later ones the stage before
        if (j == 0) begin : g_head
            assign src   = frac_in;
            assign src_q = '0;
        end else begin : g_tail
            assign src   = st_reg[j-1];
            assign src_q = q_reg[j-1];
        end

        // shift the remainder, subtract the divisor when it fits
        always_comb begin
            twice       = {src.num, 1'b0};
            diff        = twice - {1'b0, src.den};
            fits        = twice >= {1'b0, src.den};
            st_next.den = src.den;
            st_next.num = fits ? diff[FRAC_W-1:0] : twice[FRAC_W-1:0];
            q_next      = {src_q[Y_BITS-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_next;
                q_reg[j]  <= q_next;
            end
        end
    end

    assign y_out = q_reg[Y_BITS-1];

endmodule

@@ rtl/rhtm_gamma.sv @@
// gamma 1/2.2 encode rom indexed by the top bits of the tone-mapped fraction
// depends on rhtm_pkg for the table generator
module rhtm_gamma import rhtm_pkg::*; #(
    parameter int unsigned GAMMA_BITS = GAMMA_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [Y_BITS-1:0] y_in,
    output logic [7:0]        byte_reg
);

    localparam int unsigned LUT_DEPTH = 1 << GAMMA_BITS;

    logic [7:0]            lut_rom [LUT_DEPTH];
    logic [GAMMA_BITS-1:0] idx;

    // constant table, one generated entry per index
    for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_lut
        localparam logic [7:0] ENTRY = gamma_entry(i, GAMMA_BITS);
        assign lut_rom[i] = ENTRY;
    end

    assign idx = y_in[Y_BITS-1 -: GAMMA_BITS];

    // registered rom read, doubles as the output register
    always_ff @(posedge aclk) begin
        if (en) byte_reg <= lut_rom[idx];
    end

endmodule

@@ rtl/rgbe_hdr_tone_map_gamma.sv @@
// rgbe texel decode, reinhard tone map and gamma 2.2 encode, three channels in parallel
// pipeline: 1 prep, 16 divider and 1 rom stage between input beat and output beat
// throughput: one beat per cycle; the whole pipe holds only while an output beat waits
// reset: aresetn synchronous active low, clears the valid bits only
// depends on rhtm_pkg, rhtm_prep, rhtm_div, rhtm_gamma
module rgbe_hdr_tone_map_gamma import rhtm_pkg::*; #(
    parameter int unsigned GAMMA_BITS = GAMMA_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, shared_exponent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_out, green_out, blue_out
);

    localparam int unsigned LAT = Y_BITS + 2;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           adv;

    // advance whenever the output slot is free or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // one datapath per color channel
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
        frac_t             frac;
        logic [Y_BITS-1:0] y;
        logic [7:0]        pix;

        rhtm_prep u_prep (
            .aclk     (aclk),
            .en       (adv),
            .mant     (s_tdata[8*ch +: 8]),
            .expo     (s_tdata[31:24]),
            .frac_reg (frac)
        );

        rhtm_div u_div (
            .aclk    (aclk),
            .en      (adv),
            .frac_in (frac),
            .y_out   (y)
        );

        rhtm_gamma #(
            .GAMMA_BITS (GAMMA_BITS)
        ) u_gamma (
            .aclk     (aclk),
            .en       (adv),
            .y_in     (y),
            .byte_reg (pix)
        );

        assign m_tdata[8*ch +: 8] = pix;
    end

    // input side stalls only behind a blocked output beat
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked output beat");

    // pipe is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a taken output beat is replaced by the beat one stage behind
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (m_tvalid == $past(vld_reg[LAT-2])))
        else $error("pipeline lost or repeated a beat");

endmodule

@@ test/tb_rgbe_hdr_tone_map_gamma.sv @@
// testbench for rgbe_hdr_tone_map_gamma: directed and random rgbe texels, each beat
// checked against a local fixed-point tone map and gamma predictor; needs only the rtl
`timescale 1ns / 1ps

module tb_rgbe_hdr_tone_map_gamma;

    localparam int unsigned GAMMA_BITS = rhtm_pkg::GAMMA_BITS_DEF;
    localparam int unsigned LUT_SIZE = 1 << GAMMA_BITS;
    localparam longint unsigned LINEAR_MAX = 64'd16703520; // 65504 * 255
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [7:0] shared_exp;
    } texel_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } display_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // red_in, green_in, blue_in, shared_exponent
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // red_out, green_out, blue_out

    texel_t     texel_queue[$];
    display_t   display_queue[$];
    texel_t     held_texel;
    logic [7:0] gamma_lut[LUT_SIZE];
    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 87;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    rgbe_hdr_tone_map_gamma #(
        .GAMMA_BITS(GAMMA_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // reinhard fraction y = x / (1 + x) as unsigned 0.16, x = c * 2^e / 255 clamped
    function automatic logic [15:0] reinhard_frac(logic [7:0] mant, logic signed [7:0] e);
        longint unsigned num;
        longint unsigned den;
        longint unsigned lin;
        int shift;
        if (mant == 8'd0 || e <= -17) return 16'd0;
        if (e < 0) begin
            shift = -int'(e);
            num = longint'(mant) << 16;
            den = (64'd255 << shift) + longint'(mant);
        end else begin
            if (e >= 24) begin
                lin = LINEAR_MAX;
            end else begin
                lin = longint'(mant) << int'(e);
                if (lin > LINEAR_MAX) lin = LINEAR_MAX;
            end
            num = lin << 16;
            den = 64'd255 + lin;
        end
        return 16'(num / den);
    endfunction

    // table index from the top bits of the fraction
    function automatic logic [GAMMA_BITS-1:0] gamma_index(logic [15:0] y);
        return y[15 -: GAMMA_BITS];
    endfunction

    function automatic display_t predict_display(texel_t t);
        display_t d;
        d.red   = gamma_lut[gamma_index(reinhard_frac(t.red, t.shared_exp))];
        d.green = gamma_lut[gamma_index(reinhard_frac(t.green, t.shared_exp))];
        d.blue  = gamma_lut[gamma_index(reinhard_frac(t.blue, t.shared_exp))];
        return d;
    endfunction

    // mostly exponents around the interesting band, some anywhere
    function automatic texel_t random_texel();
        texel_t t;
        logic [7:0] m[3];
        int unsigned pick;
        for (int k = 0; k < 3; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) m[2'(k)] = 8'd0;
            else if (pick < 16) m[2'(k)] = 8'd255;
            else m[2'(k)] = 8'($urandom_range(255));
        end
        t.red = m[0];
        t.green = m[1];
        t.blue = m[2];
        pick = $urandom_range(99);
        if (pick < 70) t.shared_exp = 8'(int'($urandom_range(44)) - 19);
        else if (pick < 92) t.shared_exp = 8'($urandom_range(255));
        else t.shared_exp = ($urandom_range(1) != 0) ? 8'sd127 : -8'sd128;
        return t;
    endfunction

    function automatic texel_t make_texel(int r, int g, int b, int e);
        texel_t t;
        t.red = 8'(r);
        t.green = 8'(g);
        t.blue = 8'(b);
        t.shared_exp = 8'(e);
        return t;
    endfunction

    // append a texel to the pending stimulus
    function automatic void queue_texel(texel_t t);
        texel_queue.insert(texel_queue.size(), t);
    endfunction

    // input driver: presents queued texels, predicts each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                display_queue.insert(display_queue.size(), predict_display(held_texel));
            if (!s_tvalid || s_tready) begin
                if (texel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_texel = texel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {held_texel.shared_exp, held_texel.blue,
                                held_texel.green, held_texel.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output monitor: compare each beat with the oldest prediction
    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (display_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
            end else begin
                want = display_queue.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    errors++;
                    $display("%0t: red mismatch, expected %0d, actual %0d",
                             $time, want.red, m_tdata[7:0]);
                end
                if (m_tdata[15:8] !== want.green) begin
                    errors++;
                    $display("%0t: green mismatch, expected %0d, actual %0d",
                             $time, want.green, m_tdata[15:8]);
                end
                if (m_tdata[23:16] !== want.blue) begin
                    errors++;
                    $display("%0t: blue mismatch, expected %0d, actual %0d",
                             $time, want.blue, m_tdata[23:16]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // gamma table, stimulus phases and end of run
    initial begin
        logic [159:0] pow_scaled[256];
        logic [159:0] acc;
        logic [159:0] full_scale;
        logic [159:0] rhs;
        int unsigned v;

        // floor(255 * (i / 2^GAMMA_BITS)^(5/11)) by walking v upward as i grows
        full_scale = 160'd1;
        for (int k = 0; k < 11; k++) full_scale = full_scale * 160'd255;
        for (int p = 0; p < 256; p++) begin
            acc = 160'd1;
            for (int k = 0; k < 11; k++) acc = acc * 160'(p);
            pow_scaled[8'(p)] = acc << (5 * GAMMA_BITS);
        end
        v = 0;
        for (int i = 0; i < LUT_SIZE; i++) begin
            rhs = full_scale;
            for (int k = 0; k < 5; k++) rhs = rhs * 160'(i);
            while (v < 255 && pow_scaled[8'(v + 1)] <= rhs) v++;
            gamma_lut[GAMMA_BITS'(i)] = 8'(v);
        end

        // directed texels: zero, tiny, saturating and extreme exponents
        queue_texel(make_texel(0, 0, 0, 0));
        queue_texel(make_texel(255, 255, 255, 127));
        queue_texel(make_texel(255, 1, 128, -128));
        queue_texel(make_texel(255, 200, 1, -17));
        queue_texel(make_texel(255, 200, 1, -16));
        queue_texel(make_texel(1, 255, 128, -1));
        queue_texel(make_texel(1, 255, 128, 0));
        queue_texel(make_texel(1, 255, 0, 1));
        queue_texel(make_texel(255, 254, 253, 16));
        queue_texel(make_texel(1, 2, 3, 23));
        queue_texel(make_texel(1, 0, 255, 24));
        queue_texel(make_texel(0, 1, 0, 127));
        queue_texel(make_texel(170, 85, 15, 8));
        queue_texel(make_texel(85, 170, 240, -8));
        queue_texel(make_texel(128, 64, 32, 100));
        queue_texel(make_texel(127, 127, 127, -100));
        queue_texel(make_texel(255, 255, 255, -128));
        queue_texel(make_texel(255, 255, 255, 15));
        queue_texel(make_texel(2, 4, 8, 12));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // hold the sender until the directed beats have all come back
        @(negedge aclk);
        while (texel_queue.size() != 0 || s_tvalid || display_queue.size() != 0)
            @(negedge aclk);

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 87;
                recv_idle_pct = 6;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 670; n++) queue_texel(random_texel());
            while (texel_queue.size() != 0 || s_tvalid) @(negedge aclk);
        end

        while (display_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rhtm_pkg.sv
rtl/rhtm_prep.sv
rtl/rhtm_div.sv
rtl/rhtm_gamma.sv
rtl/rgbe_hdr_tone_map_gamma.sv
test/tb_rgbe_hdr_tone_map_gamma.sv
